[rtl/core/i2c_master_register_access_defines.svh]
// Assertion macros for the I2C register access master.
// No dependencies; included by the top level only.
// Each macro expands to nothing when SYNTHESIS is defined.
`ifndef I2C_MASTER_REGISTER_ACCESS_DEFINES_SVH
`define I2C_MASTER_REGISTER_ACCESS_DEFINES_SVH

`ifndef SYNTHESIS
`define ASRT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASRT_LAT2(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> ##1 (cons)) \
    else $error("assertion failed");
`else
`define ASRT_IMP(lbl, clk, rstn, ante, cons)
`define ASRT_LAT2(lbl, clk, rstn, ante, cons)
`endif

`endif

[rtl/core/i2cm_pkg.sv]
// Shared types and constants of the I2C register access master.
// No dependencies; used by the front end, queue, engine and top level.
`timescale 1ns / 1ps
`default_nettype none

package i2cm_pkg;

  localparam int QUEUE_DEPTH = 2;
  localparam int CFG_AW      = 3;
  localparam logic [15:0] PHASE_TICKS_RST = 16'd5;

  // opcodes of the input channel
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;

  // configuration register index
  localparam logic REG_PHASE_TICKS = 1'b0;

  typedef enum logic [1:0] {
    K_TICK  = 2'd0,
    K_READ  = 2'd1,
    K_WRITE = 2'd2,
    K_NONE  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    BS_ADDR  = 2'd0,
    BS_REG   = 2'd1,
    BS_DATA  = 2'd2,
    BS_RADDR = 2'd3
  } byte_stage_t;

  typedef enum logic [19:0] {
    PH_IDLE     = 20'h00001,
    PH_START_A  = 20'h00002,
    PH_START_B  = 20'h00004,
    PH_START_C  = 20'h00008,
    PH_TX_LOW   = 20'h00010,
    PH_TX_SET   = 20'h00020,
    PH_TX_HIGH  = 20'h00040,
    PH_ACK_LOW  = 20'h00080,
    PH_ACK_REL  = 20'h00100,
    PH_ACK_HIGH = 20'h00200,
    PH_RX_LOW   = 20'h00400,
    PH_RX_HIGH  = 20'h00800,
    PH_MA_LOW   = 20'h01000,
    PH_MA_SET   = 20'h02000,
    PH_MA_HIGH  = 20'h04000,
    PH_MA_END   = 20'h08000,
    PH_STOP_A   = 20'h10000,
    PH_STOP_B   = 20'h20000,
    PH_STOP_C   = 20'h40000,
    PH_STOP_D   = 20'h80000
  } phase_t;

  typedef struct packed {
    kind_t      kind;
    logic [6:0] dev_addr;
    logic [7:0] reg_addr;
    logic [7:0] write_data;
    logic [7:0] read_count;
    logic       sda_in;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic       scl_drive;
    logic       sda_drive;
    logic       busy_res;
    logic       read_valid;
    logic [7:0] read_data;
    logic       last_byte;
    logic       done_res;
    logic       success;
  } result_t;

endpackage

`default_nettype wire

[rtl/core/i2cm_if.sv]
// Valid/ready channel interfaces of the I2C register access master.
// No dependencies; used by the front, engine and top level.
`timescale 1ns / 1ps
`default_nettype none

interface i2cm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [6:0] dev_addr;
  logic [7:0] reg_addr;
  logic [7:0] write_data;
  logic [7:0] read_count;
  logic       sda_in;

  modport source (output valid, opcode, dev_addr, reg_addr, write_data, read_count, sda_in,
                  input ready);
  modport sink (input valid, opcode, dev_addr, reg_addr, write_data, read_count, sda_in,
                output ready);
endinterface

interface i2cm_out_if;
  logic       valid;
  logic       ready;
  logic       scl_drive;
  logic       sda_drive;
  logic       busy_res;
  logic       read_valid;
  logic [7:0] read_data;
  logic       last_byte;
  logic       done_res;
  logic       success;

  modport source (output valid, scl_drive, sda_drive, busy_res, read_valid, read_data,
                  last_byte, done_res, success, input ready);
  modport sink (input valid, scl_drive, sda_drive, busy_res, read_valid, read_data,
                last_byte, done_res, success, output ready);
endinterface

`default_nettype wire

[rtl/core/i2cm_front.sv]
// Front end: takes input beats, classifies the opcode, fixes read_count.
// Depends on i2cm_pkg and i2cm_if.
`timescale 1ns / 1ps
`default_nettype none

module i2cm_front (
  i2cm_in_if.sink          in_ch,
  input  i2cm_pkg::q_stat_t q_stat,
  output logic             push,
  output i2cm_pkg::entry_t push_entry
);

  assign in_ch.ready = !q_stat.full;
  assign push        = in_ch.valid && !q_stat.full;

  always_comb begin
    case (in_ch.opcode)
      i2cm_pkg::OP_TICK:  push_entry.kind = i2cm_pkg::K_TICK;
      i2cm_pkg::OP_READ:  push_entry.kind = i2cm_pkg::K_READ;
      i2cm_pkg::OP_WRITE: push_entry.kind = i2cm_pkg::K_WRITE;
      default:            push_entry.kind = i2cm_pkg::K_NONE;
    endcase
    push_entry.dev_addr   = in_ch.dev_addr;
    push_entry.reg_addr   = in_ch.reg_addr;
    push_entry.write_data = in_ch.write_data;
    // zero bytes is read as one
    push_entry.read_count = (in_ch.read_count == 8'd0) ? 8'd1 : in_ch.read_count;
    push_entry.sda_in     = in_ch.sda_in;
  end

endmodule

`default_nettype wire

[rtl/core/i2cm_queue.sv]
// Small FIFO between the front end and the bus engine.
// Depends on i2cm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module i2cm_queue #(
  parameter int DEPTH = i2cm_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  i2cm_pkg::entry_t  push_entry,
  input  logic              pop,
  output i2cm_pkg::entry_t  head,
  output i2cm_pkg::q_stat_t stat
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  i2cm_pkg::entry_t slot_r [DEPTH];
  logic [IW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [IW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign stat.full  = (cnt_r == CW'(DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == IW'(DEPTH - 1)) ? '0 : wr_ptr_r + IW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == IW'(DEPTH - 1)) ? '0 : rd_ptr_r + IW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

`default_nettype wire

[rtl/core/i2cm_engine.sv]
// Bus engine: advances the I2C phase machine on queued beats and registers
// one result beat per beat. Depends on i2cm_pkg and i2cm_if.
`timescale 1ns / 1ps
`default_nettype none

module i2cm_engine (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [15:0]          phase_ticks,
  input  i2cm_pkg::entry_t     head,
  input  i2cm_pkg::q_stat_t    q_stat,
  output logic                 pop,
  i2cm_out_if.source           out_ch
);

  i2cm_pkg::phase_t      ph_r, ph_nxt;
  i2cm_pkg::byte_stage_t bs_r, bs_nxt;
  logic [15:0] tc_r, tc_nxt;
  logic [3:0]  bc_r, bc_nxt;
  logic [7:0]  sh_r, sh_nxt;
  logic [7:0]  bl_r, bl_nxt;
  logic        rd_r, rd_nxt;
  logic [6:0]  ha_r, ha_nxt;
  logic [7:0]  hr_r, hr_nxt;
  logic [7:0]  hd_r, hd_nxt;
  logic        ok_r, ok_nxt;
  logic        scl_r, scl_nxt;
  logic        sda_r, sda_nxt;
  logic        out_vld_r;
  i2cm_pkg::result_t res_r, res_nxt;

  logic [15:0] limit;
  logic [16:0] tc_inc;
  logic [3:0]  bc_inc;
  logic [7:0]  rx_byte;
  logic        phase_end;
  logic        enter_en;
  logic        rvalid, last, done, succ;
  logic [7:0]  rdata;

  assign pop       = !q_stat.empty && (!out_vld_r || out_ch.ready);
  assign limit     = (phase_ticks == 16'd0) ? 16'd1 : phase_ticks;
  assign tc_inc    = {1'b0, tc_r} + 17'd1;
  assign phase_end = (tc_inc >= {1'b0, limit});
  assign bc_inc    = bc_r + 4'd1;
  assign rx_byte   = {sh_r[6:0], head.sda_in};

  // next phase and datapath
  always_comb begin
    ph_nxt   = ph_r;
    bs_nxt   = bs_r;
    tc_nxt   = tc_r;
    bc_nxt   = bc_r;
    sh_nxt   = sh_r;
    bl_nxt   = bl_r;
    rd_nxt   = rd_r;
    ha_nxt   = ha_r;
    hr_nxt   = hr_r;
    hd_nxt   = hd_r;
    ok_nxt   = ok_r;
    enter_en = 1'b0;
    rvalid   = 1'b0;
    rdata    = 8'd0;
    last     = 1'b0;
    done     = 1'b0;
    succ     = 1'b0;
    if (pop) begin
      if (ph_r == i2cm_pkg::PH_IDLE) begin
        if (head.kind == i2cm_pkg::K_READ || head.kind == i2cm_pkg::K_WRITE) begin
          rd_nxt   = (head.kind == i2cm_pkg::K_READ);
          ha_nxt   = head.dev_addr;
          hr_nxt   = head.reg_addr;
          hd_nxt   = head.write_data;
          bl_nxt   = head.read_count;
          ok_nxt   = 1'b1;
          bs_nxt   = i2cm_pkg::BS_ADDR;
          bc_nxt   = 4'd0;
          ph_nxt   = i2cm_pkg::PH_START_A;
          enter_en = 1'b1;
        end
      end else if (head.kind == i2cm_pkg::K_TICK) begin
        if (!phase_end) begin
          tc_nxt = tc_inc[15:0];
        end else begin
          enter_en = 1'b1;
          case (ph_r)
            i2cm_pkg::PH_START_A: begin
              if (head.sda_in) begin
                ph_nxt = i2cm_pkg::PH_START_B;
              end else begin
                ok_nxt = 1'b0;
                ph_nxt = i2cm_pkg::PH_STOP_A;
              end
            end
            i2cm_pkg::PH_START_B: begin
              if (!head.sda_in) begin
                ph_nxt = i2cm_pkg::PH_START_C;
              end else begin
                ok_nxt = 1'b0;
                ph_nxt = i2cm_pkg::PH_STOP_A;
              end
            end
            i2cm_pkg::PH_START_C: begin
              // after a repeated start the address goes out with R/W high
              if (bs_r == i2cm_pkg::BS_DATA) begin
                bs_nxt = i2cm_pkg::BS_RADDR;
                sh_nxt = {ha_r, 1'b1};
              end else begin
                sh_nxt = {ha_r, 1'b0};
              end
              bc_nxt = 4'd0;
              ph_nxt = i2cm_pkg::PH_TX_LOW;
            end
            i2cm_pkg::PH_TX_LOW: ph_nxt = i2cm_pkg::PH_TX_SET;
            i2cm_pkg::PH_TX_SET: ph_nxt = i2cm_pkg::PH_TX_HIGH;
            i2cm_pkg::PH_TX_HIGH: begin
              sh_nxt = {sh_r[6:0], 1'b0};
              bc_nxt = bc_inc;
              ph_nxt = (bc_inc >= 4'd8) ? i2cm_pkg::PH_ACK_LOW : i2cm_pkg::PH_TX_LOW;
            end
            i2cm_pkg::PH_ACK_LOW: ph_nxt = i2cm_pkg::PH_ACK_REL;
            i2cm_pkg::PH_ACK_REL: ph_nxt = i2cm_pkg::PH_ACK_HIGH;
            i2cm_pkg::PH_ACK_HIGH: begin
              if (head.sda_in) begin
                ok_nxt = 1'b0;
                ph_nxt = i2cm_pkg::PH_STOP_A;
              end else begin
                case (bs_r)
                  i2cm_pkg::BS_ADDR: begin
                    bs_nxt = i2cm_pkg::BS_REG;
                    sh_nxt = hr_r;
                    bc_nxt = 4'd0;
                    ph_nxt = i2cm_pkg::PH_TX_LOW;
                  end
                  i2cm_pkg::BS_REG: begin
                    bs_nxt = i2cm_pkg::BS_DATA;
                    if (rd_r) begin
                      ph_nxt = i2cm_pkg::PH_START_A;
                    end else begin
                      sh_nxt = hd_r;
                      bc_nxt = 4'd0;
                      ph_nxt = i2cm_pkg::PH_TX_LOW;
                    end
                  end
                  i2cm_pkg::BS_RADDR: begin
                    sh_nxt = 8'd0;
                    bc_nxt = 4'd0;
                    ph_nxt = i2cm_pkg::PH_RX_LOW;
                  end
                  default: ph_nxt = i2cm_pkg::PH_STOP_A;
                endcase
              end
            end
            i2cm_pkg::PH_RX_LOW: ph_nxt = i2cm_pkg::PH_RX_HIGH;
            i2cm_pkg::PH_RX_HIGH: begin
              sh_nxt = rx_byte;
              bc_nxt = bc_inc;
              if (bc_inc >= 4'd8) begin
                bl_nxt = bl_r - 8'd1;
                rvalid = 1'b1;
                rdata  = rx_byte;
                last   = (bl_r == 8'd1);
                ph_nxt = i2cm_pkg::PH_MA_LOW;
              end else begin
                ph_nxt = i2cm_pkg::PH_RX_LOW;
              end
            end
            i2cm_pkg::PH_MA_LOW:  ph_nxt = i2cm_pkg::PH_MA_SET;
            i2cm_pkg::PH_MA_SET:  ph_nxt = i2cm_pkg::PH_MA_HIGH;
            i2cm_pkg::PH_MA_HIGH: ph_nxt = i2cm_pkg::PH_MA_END;
            i2cm_pkg::PH_MA_END: begin
              if (bl_r != 8'd0) begin
                sh_nxt = 8'd0;
                bc_nxt = 4'd0;
                ph_nxt = i2cm_pkg::PH_RX_LOW;
              end else begin
                ph_nxt = i2cm_pkg::PH_STOP_A;
              end
            end
            i2cm_pkg::PH_STOP_A: ph_nxt = i2cm_pkg::PH_STOP_B;
            i2cm_pkg::PH_STOP_B: ph_nxt = i2cm_pkg::PH_STOP_C;
            i2cm_pkg::PH_STOP_C: ph_nxt = i2cm_pkg::PH_STOP_D;
            default: begin
              done   = 1'b1;
              succ   = ok_r;
              ph_nxt = i2cm_pkg::PH_IDLE;
            end
          endcase
        end
      end
    end
    if (enter_en) begin
      tc_nxt = 16'd0;
    end
  end

  // line levels set on entry to a phase
  always_comb begin
    scl_nxt = scl_r;
    sda_nxt = sda_r;
    if (enter_en) begin
      case (ph_nxt)
        i2cm_pkg::PH_START_A: begin
          scl_nxt = 1'b1;
          sda_nxt = 1'b1;
        end
        i2cm_pkg::PH_START_B, i2cm_pkg::PH_START_C: begin
          scl_nxt = 1'b1;
          sda_nxt = 1'b0;
        end
        i2cm_pkg::PH_TX_LOW, i2cm_pkg::PH_ACK_LOW, i2cm_pkg::PH_MA_LOW,
        i2cm_pkg::PH_MA_END, i2cm_pkg::PH_STOP_A: begin
          scl_nxt = 1'b0;
        end
        i2cm_pkg::PH_TX_SET: begin
          scl_nxt = 1'b0;
          sda_nxt = sh_nxt[7];
        end
        i2cm_pkg::PH_TX_HIGH, i2cm_pkg::PH_MA_HIGH: begin
          scl_nxt = 1'b1;
        end
        i2cm_pkg::PH_ACK_REL, i2cm_pkg::PH_RX_LOW: begin
          scl_nxt = 1'b0;
          sda_nxt = 1'b1;
        end
        i2cm_pkg::PH_ACK_HIGH, i2cm_pkg::PH_RX_HIGH: begin
          scl_nxt = 1'b1;
          sda_nxt = 1'b1;
        end
        i2cm_pkg::PH_MA_SET: begin
          // ACK every byte but the last, NACK the last
          scl_nxt = 1'b0;
          sda_nxt = (bl_nxt == 8'd0);
        end
        i2cm_pkg::PH_STOP_B: begin
          scl_nxt = 1'b0;
          sda_nxt = 1'b0;
        end
        i2cm_pkg::PH_STOP_C: begin
          scl_nxt = 1'b1;
          sda_nxt = 1'b0;
        end
        default: begin
          scl_nxt = 1'b1;
          sda_nxt = 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    res_nxt.scl_drive  = scl_nxt;
    res_nxt.sda_drive  = sda_nxt;
    res_nxt.busy_res   = (ph_nxt != i2cm_pkg::PH_IDLE);
    res_nxt.read_valid = rvalid;
    res_nxt.read_data  = rdata;
    res_nxt.last_byte  = last;
    res_nxt.done_res   = done;
    res_nxt.success    = succ;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r      <= i2cm_pkg::PH_IDLE;
      bs_r      <= i2cm_pkg::BS_ADDR;
      tc_r      <= '0;
      bc_r      <= '0;
      sh_r      <= '0;
      bl_r      <= '0;
      rd_r      <= 1'b0;
      ha_r      <= '0;
      hr_r      <= '0;
      hd_r      <= '0;
      ok_r      <= 1'b1;
      scl_r     <= 1'b1;
      sda_r     <= 1'b1;
      out_vld_r <= 1'b0;
    end else begin
      ph_r  <= ph_nxt;
      bs_r  <= bs_nxt;
      tc_r  <= tc_nxt;
      bc_r  <= bc_nxt;
      sh_r  <= sh_nxt;
      bl_r  <= bl_nxt;
      rd_r  <= rd_nxt;
      ha_r  <= ha_nxt;
      hr_r  <= hr_nxt;
      hd_r  <= hd_nxt;
      ok_r  <= ok_nxt;
      scl_r <= scl_nxt;
      sda_r <= sda_nxt;
      if (pop) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid      = out_vld_r;
  assign out_ch.scl_drive  = res_r.scl_drive;
  assign out_ch.sda_drive  = res_r.sda_drive;
  assign out_ch.busy_res   = res_r.busy_res;
  assign out_ch.read_valid = res_r.read_valid;
  assign out_ch.read_data  = res_r.read_data;
  assign out_ch.last_byte  = res_r.last_byte;
  assign out_ch.done_res   = res_r.done_res;
  assign out_ch.success    = res_r.success;

endmodule

`default_nettype wire

[rtl/core/i2c_master_register_access.sv]
// Top level of the I2C register access master: config register, front end,
// beat queue and bus engine. Depends on i2cm_pkg, i2cm_if and the defines header.
//
//   channel  | kind           | carries
//   ---------+----------------+------------------------------------------------
//   in_if    | valid/ready in | opcode, dev_addr, reg_addr, write_data, ...
//   out_if   | valid/ready out| scl/sda levels, status, read byte, done/success
//   apb      | APB slave      | phase_ticks at byte address 0
//
// One beat is accepted per cycle while the queue is not full; its result beat passes
// through a queue slot and then the engine's output register.
// Queue of QUEUE_DEPTH beats absorbs output stalls; in_if.ready drops when full.
// Reset is synchronous; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
`include "i2c_master_register_access_defines.svh"

module i2c_master_register_access #(
  parameter int QUEUE_DEPTH = i2cm_pkg::QUEUE_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  i2cm_in_if.sink                     in_if,
  i2cm_out_if.source                  out_if,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [i2cm_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  logic [15:0]       phase_ticks_r, phase_ticks_nxt;
  logic              cfg_wr;
  logic              push;
  logic              pop;
  i2cm_pkg::entry_t  push_entry;
  i2cm_pkg::entry_t  head;
  i2cm_pkg::q_stat_t q_stat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    phase_ticks_nxt = phase_ticks_r;
    if (cfg_wr && paddr[2] == i2cm_pkg::REG_PHASE_TICKS) begin
      phase_ticks_nxt = pwdata[15:0];
    end
  end

  assign prdata = (paddr[2] == i2cm_pkg::REG_PHASE_TICKS) ? {16'd0, phase_ticks_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_ticks_r <= i2cm_pkg::PHASE_TICKS_RST;
    end else begin
      phase_ticks_r <= phase_ticks_nxt;
    end
  end

  i2cm_front u_front (
    .in_ch      (in_if),
    .q_stat     (q_stat),
    .push       (push),
    .push_entry (push_entry)
  );

  i2cm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .stat       (q_stat)
  );

  i2cm_engine u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .phase_ticks (phase_ticks_r),
    .head        (head),
    .q_stat      (q_stat),
    .pop         (pop),
    .out_ch      (out_if)
  );

  // a finished stop always leaves the engine idle
  `ASRT_IMP(a_done_idle, clk, rst_n, out_if.valid && out_if.done_res, !out_if.busy_res)
  `ASRT_IMP(a_succ_done, clk, rst_n, out_if.valid && out_if.success, out_if.done_res)
  `ASRT_IMP(a_last_rx, clk, rst_n, out_if.valid && out_if.last_byte, out_if.read_valid && !out_if.done_res)
  // beat into an empty pipe shows up at the output after the queue slot and the output register
  `ASRT_LAT2(a_latency, clk, rst_n, in_if.valid && in_if.ready && q_stat.empty && !out_if.valid, out_if.valid)

endmodule

`default_nettype wire
